// ===== rtl/core/egt_plf_pkg.sv =====
// Shared types and constants of the exhaust-temperature peak finder.
// No dependencies; used by every module under rtl/core.
`timescale 1ns / 1ps
`default_nettype none
package egt_plf_pkg;

  localparam int TEMP_W      = 12;  // temperature and threshold width
  localparam int DELTA_W     = 13;  // signed current-minus-peak
  localparam int TIME_W      = 32;
  localparam int HOLD_W      = 16;
  localparam int CYL_W       = 3;   // cylinder index / count width
  localparam int CMD_W       = 2;
  localparam int NUM_TEMP_IN = 6;   // temperatures carried per frame
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam int IN_DATA_W   = 104; // now_ms + six temperatures, byte aligned
  localparam int IN_USER_W   = 8;   // command, zero filled
  localparam int OUT_DATA_W  = 40;  // 37 bits of result, zero filled

  // register reset values
  localparam logic [TEMP_W-1:0] ARM_RISE_RST  = 12'd20;
  localparam logic [TEMP_W-1:0] PEAK_DROP_RST = 12'd10;
  localparam logic [CYL_W-1:0]  CYL_USE_RST   = 3'd6;
  localparam logic [HOLD_W-1:0] HOLD_MS_RST   = 16'd900;

  typedef logic [TEMP_W-1:0] temp_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ARM_RISE  = 2'd0,
    CFG_PEAK_DROP = 2'd1,
    CFG_CYL_USE   = 2'd2,
    CFG_HOLD_MS   = 2'd3
  } cfg_reg_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_FRAME = 2'd0,
    CMD_START = 2'd1,
    CMD_EXIT  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_PRE   = 3'd1,
    PH_LEAN  = 3'd2,
    PH_FOUND = 3'd3,
    PH_FINAL = 3'd4
  } phase_t;

  // per-lane control from the sequencer
  typedef struct packed {
    logic active;    // lane index below the cylinder count
    logic snapshot;  // load baseline and peak from this frame
    logic track;     // update running peak
  } lane_ctrl_t;

  // per-lane findings toward the merge stage
  typedef struct packed {
    logic  active;
    temp_t temp;
    logic  arm_hit;
    logic  drop_hit;
  } lane_info_t;

  // merged findings over all lanes
  typedef struct packed {
    logic [CYL_W-1:0] hot_idx;
    logic             any_arm;
    logic             drop_found;
    logic [CYL_W-1:0] drop_idx;
  } merge_t;

endpackage
`default_nettype wire

// ===== rtl/core/egt_plf_lane.sv =====
// One cylinder lane: baseline and running peak registers plus the
// arm and drop compares. Depends on egt_plf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module egt_plf_lane (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       update,     // frame request accepted
  input  egt_plf_pkg::lane_ctrl_t   ctrl,
  input  egt_plf_pkg::temp_t        temp,
  input  egt_plf_pkg::temp_t        arm_rise,
  input  egt_plf_pkg::temp_t        peak_drop,
  output egt_plf_pkg::temp_t        peak_now,
  output egt_plf_pkg::temp_t        peak_next,
  output egt_plf_pkg::lane_info_t   info
);

  egt_plf_pkg::temp_t baseline;
  egt_plf_pkg::temp_t peak;
  logic [egt_plf_pkg::TEMP_W:0] arm_level;
  logic [egt_plf_pkg::TEMP_W:0] drop_level;

  always_comb begin
    peak_next = peak;
    if (ctrl.active && ctrl.snapshot) begin
      peak_next = temp;
    end else if (ctrl.active && ctrl.track && (temp > peak)) begin
      peak_next = temp;
    end
  end

  // t - base >= rise  <=>  t >= base + rise, widened by one bit
  assign arm_level  = {1'b0, baseline} + {1'b0, arm_rise};
  assign drop_level = {1'b0, temp} + {1'b0, peak_drop};

  always_comb begin
    info.active   = ctrl.active;
    info.temp     = temp;
    info.arm_hit  = ctrl.active && ({1'b0, temp} >= arm_level);
    info.drop_hit = ctrl.active && ({1'b0, peak_next} >= drop_level);
  end

  assign peak_now = peak;

  always_ff @(posedge clk) begin
    if (rst) begin
      baseline <= '0;
      peak     <= '0;
    end else if (update) begin
      if (ctrl.active && ctrl.snapshot) begin
        baseline <= temp;
      end
      peak <= peak_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/egt_plf_merge.sv =====
// Merge stage: hottest cylinder, any-arm reduction and first peaked lane.
// Depends on egt_plf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module egt_plf_merge #(
  parameter int MAX_CYLINDERS = 6
) (
  input  egt_plf_pkg::lane_info_t info [MAX_CYLINDERS],
  output egt_plf_pkg::merge_t     merged
);

  always_comb begin
    logic [egt_plf_pkg::CYL_W-1:0] hot;
    egt_plf_pkg::temp_t            hot_temp;
    logic                          arm;
    logic                          found;
    logic [egt_plf_pkg::CYL_W-1:0] idx;
    hot      = '0;
    hot_temp = info[0].temp;
    arm      = 1'b0;
    found    = 1'b0;
    idx      = '0;
    // strict compare keeps the lowest index on ties
    for (int i = 1; i < MAX_CYLINDERS; i++) begin
      if (info[i].active && (info[i].temp > hot_temp)) begin
        hot      = egt_plf_pkg::CYL_W'(i);
        hot_temp = info[i].temp;
      end
    end
    for (int i = 0; i < MAX_CYLINDERS; i++) begin
      arm = arm | info[i].arm_hit;
    end
    // scan from the top so the lowest hit wins
    for (int i = MAX_CYLINDERS - 1; i >= 0; i--) begin
      if (info[i].drop_hit) begin
        found = 1'b1;
        idx   = egt_plf_pkg::CYL_W'(i);
      end
    end
    merged.hot_idx    = hot;
    merged.any_arm    = arm;
    merged.drop_found = found;
    merged.drop_idx   = idx;
  end

endmodule
`default_nettype wire

// ===== rtl/core/egt_plf_finder_core.sv =====
// Top level of the exhaust-temperature peak finder: phase sequencer, cylinder
// lanes, merge stage and two-entry result buffer. Uses egt_plf_pkg, egt_plf_lane, egt_plf_merge.
// The result of a frame request is registered into the result buffer at the edge that
//   accepts it. Throughput: one frame per cycle; s_axis_tready drops only while both
//   result entries are full, and is low during reset.
// Reset (rst, synchronous): idle phase, flags, baselines, peaks cleared; registers at defaults.
`timescale 1ns / 1ps
`default_nettype none
module egt_peak_lean_finder_core #(
  parameter int MAX_CYLINDERS = 6   // 1..8 lanes
) (
  input  wire         clk,
  input  wire         rst,
  // configuration writes
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_index,
  input  wire  [15:0] cfg_data,
  // frame requests
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // [31:0] now_ms, then temp_cyl0..temp_cyl5 at 12 bits each from bit 32
  input  wire  [103:0] s_axis_tdata,
  // [1:0] command, [7:2] zero
  input  wire  [7:0]  s_axis_tuser,
  // result requests
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // [2:0] phase_now, [3] phase_changed, [4] is_armed, [7:5] hottest_cyl,
  // [8] peaked_valid, [11:9] peaked_cyl, [23:12] peak_temp,
  // [36:24] below_peak, [39:37] zero
  output logic [39:0] m_axis_tdata
);
  // A frame's result is registered at the edge that accepts the frame.
  // Throughput: one frame per cycle; all per-cylinder compares run in
  //   parallel lanes and the merge is a short priority chain.
  // The result buffer holds two entries, so frames keep flowing while one
  //   result waits; s_axis_tready drops only when both entries are full.
  // Reset (rst, synchronous): idle phase, flags, baselines and peaks
  //   cleared, registers back to arm_rise 20, peak_drop 10, six cylinders,
  //   900 ms hold.

  localparam int IDX_W = (MAX_CYLINDERS > 1) ? $clog2(MAX_CYLINDERS) : 1;
  localparam int TW    = egt_plf_pkg::TEMP_W;
  localparam int CW    = egt_plf_pkg::CYL_W;

  // ---------------- configuration ----------------
  egt_plf_pkg::temp_t                 arm_rise;
  egt_plf_pkg::temp_t                 peak_drop;
  logic [CW-1:0]                      cyl_use;
  logic [egt_plf_pkg::HOLD_W-1:0]     hold_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      arm_rise  <= egt_plf_pkg::ARM_RISE_RST;
      peak_drop <= egt_plf_pkg::PEAK_DROP_RST;
      cyl_use   <= egt_plf_pkg::CYL_USE_RST;
      hold_ms   <= egt_plf_pkg::HOLD_MS_RST;
    end else if (cfg_we) begin
      case (egt_plf_pkg::cfg_reg_t'(cfg_index))
        egt_plf_pkg::CFG_ARM_RISE:  arm_rise  <= cfg_data[TW-1:0];
        egt_plf_pkg::CFG_PEAK_DROP: peak_drop <= cfg_data[TW-1:0];
        egt_plf_pkg::CFG_CYL_USE:   cyl_use   <= cfg_data[CW-1:0];
        egt_plf_pkg::CFG_HOLD_MS:   hold_ms   <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective cylinder count: 0 reads as 1, saturates at the lane count
  logic [CW:0] n_eff;
  always_comb begin
    if (cyl_use == '0) begin
      n_eff = (CW + 1)'(1);
    end else if ({1'b0, cyl_use} > (CW + 1)'(MAX_CYLINDERS)) begin
      n_eff = (CW + 1)'(MAX_CYLINDERS);
    end else begin
      n_eff = {1'b0, cyl_use};
    end
  end

  // ---------------- request decode ----------------
  logic                           in_fire;
  logic [egt_plf_pkg::CMD_W-1:0]  cmd;
  logic [egt_plf_pkg::TIME_W-1:0] now_ms;

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign cmd     = s_axis_tuser[egt_plf_pkg::CMD_W-1:0];
  assign now_ms  = s_axis_tdata[egt_plf_pkg::TIME_W-1:0];

  // ---------------- sequencer state ----------------
  egt_plf_pkg::phase_t              phase, phase_next;
  logic [egt_plf_pkg::TIME_W-1:0]   phase_start, phase_start_next;
  logic                             armed, armed_next;
  logic                             peaked, peaked_next;
  logic [CW-1:0]                    peaked_idx, peaked_idx_next;
  logic signed [egt_plf_pkg::DELTA_W-1:0] delta, delta_next;
  logic                             snapshot, track;

  // ---------------- lanes ----------------
  egt_plf_pkg::temp_t      lane_temp [MAX_CYLINDERS];
  egt_plf_pkg::temp_t      lane_peak [MAX_CYLINDERS];
  egt_plf_pkg::temp_t      lane_peak_next [MAX_CYLINDERS];
  egt_plf_pkg::lane_info_t lane_info [MAX_CYLINDERS];
  egt_plf_pkg::lane_ctrl_t lane_ctrl [MAX_CYLINDERS];
  egt_plf_pkg::merge_t     merged;

  for (genvar i = 0; i < MAX_CYLINDERS; i++) begin : g_lane
    if (i < egt_plf_pkg::NUM_TEMP_IN) begin : g_temp
      assign lane_temp[i] = s_axis_tdata[egt_plf_pkg::TIME_W + TW*i +: TW];
    end else begin : g_none
      assign lane_temp[i] = '0;  // lanes beyond the frame see zero
    end

    always_comb begin
      lane_ctrl[i].active   = (CW + 1)'(i) < n_eff;
      lane_ctrl[i].snapshot = snapshot;
      lane_ctrl[i].track    = track;
    end

    egt_plf_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .update    (in_fire),
      .ctrl      (lane_ctrl[i]),
      .temp      (lane_temp[i]),
      .arm_rise  (arm_rise),
      .peak_drop (peak_drop),
      .peak_now  (lane_peak[i]),
      .peak_next (lane_peak_next[i]),
      .info      (lane_info[i])
    );
  end

  egt_plf_merge #(
    .MAX_CYLINDERS (MAX_CYLINDERS)
  ) u_merge (
    .info   (lane_info),
    .merged (merged)
  );

  // ---------------- phase sequencing ----------------
  logic [egt_plf_pkg::TIME_W-1:0] elapsed;
  logic                           hold_done;
  logic [IDX_W-1:0]               k_idx;

  assign elapsed   = now_ms - phase_start;  // wraps modulo 2^32
  assign hold_done = elapsed >= {{(egt_plf_pkg::TIME_W - egt_plf_pkg::HOLD_W){1'b0}}, hold_ms};
  assign k_idx     = ({1'b0, peaked_idx} < (CW + 1)'(MAX_CYLINDERS)) ?
                     peaked_idx[IDX_W-1:0] : '0;

  always_comb begin
    phase_next      = phase;
    armed_next      = armed;
    peaked_next     = peaked;
    peaked_idx_next = peaked_idx;
    delta_next      = delta;
    snapshot        = 1'b0;
    track           = 1'b0;

    if (cmd == egt_plf_pkg::CMD_START && phase == egt_plf_pkg::PH_IDLE) begin
      phase_next      = egt_plf_pkg::PH_PRE;
      armed_next      = 1'b0;
      peaked_next     = 1'b0;
      peaked_idx_next = '0;
      delta_next      = '0;
    end else if (cmd == egt_plf_pkg::CMD_EXIT) begin
      if (phase != egt_plf_pkg::PH_IDLE) begin
        phase_next      = egt_plf_pkg::PH_IDLE;
        armed_next      = 1'b0;
        peaked_next     = 1'b0;
        peaked_idx_next = '0;
        delta_next      = '0;
      end
    end else if (phase != egt_plf_pkg::PH_IDLE) begin
      // start while active and the unused code both act as a frame update
      if (phase == egt_plf_pkg::PH_PRE && hold_done) begin
        phase_next = egt_plf_pkg::PH_LEAN;
        snapshot   = 1'b1;
      end
      if (phase_next == egt_plf_pkg::PH_FOUND && hold_done) begin
        phase_next = egt_plf_pkg::PH_FINAL;
      end
      if (phase_next == egt_plf_pkg::PH_FINAL && peaked) begin
        delta_next = $signed({1'b0, lane_temp[k_idx]}) - $signed({1'b0, lane_peak[k_idx]});
      end
      if (phase_next == egt_plf_pkg::PH_LEAN) begin
        if (snapshot) begin
          // entry frame only loads baselines and peaks
          armed_next      = 1'b0;
          peaked_next     = 1'b0;
          peaked_idx_next = '0;
          delta_next      = '0;
        end else begin
          track      = 1'b1;
          armed_next = armed || merged.any_arm;
          if (armed_next && merged.drop_found) begin
            peaked_idx_next = merged.drop_idx;
            peaked_next     = 1'b1;
            phase_next      = egt_plf_pkg::PH_FOUND;
          end
        end
      end
    end

    phase_start_next = (phase_next != phase) ? now_ms : phase_start;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= egt_plf_pkg::PH_IDLE;
      phase_start <= '0;
      armed       <= 1'b0;
      peaked      <= 1'b0;
      peaked_idx  <= '0;
      delta       <= '0;
    end else if (in_fire) begin
      phase       <= phase_next;
      phase_start <= phase_start_next;
      armed       <= armed_next;
      peaked      <= peaked_next;
      peaked_idx  <= peaked_idx_next;
      delta       <= delta_next;
    end
  end

  // ---------------- result word ----------------
  logic [IDX_W-1:0]                   p_idx;
  egt_plf_pkg::temp_t                 res_peak;
  logic [egt_plf_pkg::OUT_DATA_W-1:0] res_word;

  assign p_idx    = ({1'b0, peaked_idx_next} < (CW + 1)'(MAX_CYLINDERS)) ?
                    peaked_idx_next[IDX_W-1:0] : '0;
  assign res_peak = peaked_next ? lane_peak_next[p_idx] : '0;

  always_comb begin
    res_word        = '0;
    res_word[2:0]   = phase_next;
    res_word[3]     = phase_next != phase;
    res_word[4]     = armed_next;
    res_word[7:5]   = merged.hot_idx;
    res_word[8]     = peaked_next;
    res_word[11:9]  = peaked_next ? peaked_idx_next : '0;
    res_word[23:12] = res_peak;
    res_word[36:24] = (phase_next == egt_plf_pkg::PH_FINAL) ? delta_next : '0;
  end

  // ---------------- two-entry result buffer ----------------
  logic                               skid_valid;
  logic [egt_plf_pkg::OUT_DATA_W-1:0] skid_word;
  logic                               out_free;

  // no request is taken while reset is held
  assign s_axis_tready = !skid_valid && !rst;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_valid    <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        m_axis_tvalid <= 1'b1;
        skid_valid    <= in_fire;
      end else begin
        m_axis_tvalid <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        m_axis_tdata <= skid_word;
        if (in_fire) begin
          skid_word <= res_word;
        end
      end else if (in_fire) begin
        m_axis_tdata <= res_word;
      end
    end else if (in_fire) begin
      skid_word <= res_word;
    end
  end

endmodule
`default_nettype wire

// ===== tb/tb_egt_peak_lean_finder_core.sv =====
// Self-checking bench for egt_peak_lean_finder_core: directed frame table, then
// randomized lean-find sessions, checked against a built-in peak-finder predictor.
// Depends on egt_plf_pkg and the core RTL only.
`timescale 1ns / 1ps
module tb_egt_peak_lean_finder_core;
  import egt_plf_pkg::*;

  localparam int CLK_HALF       = 2;       // 4 ns period
  localparam int RESET_CYCLES   = 11;
  localparam int LANES          = 6;       // default MAX_CYLINDERS of the core
  localparam int ITEM_TARGET    = 1050;
  localparam int QUIET_CYCLES   = 6;       // settle time before register writes
  localparam int HOLD_OFF       = 200;     // long receiver stall, in cycles
  localparam int TIMEOUT_CYCLES = 400000;
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;  // unused code, acts as a frame

  // one frame request as seen on the input bus
  typedef struct packed {
    logic [CMD_W-1:0]              cmd;
    logic [TIME_W-1:0]             now;
    logic [LANES-1:0][TEMP_W-1:0]  temp;
  } frame_t;

  // result bus layout, highest field first
  typedef struct packed {
    logic [2:0]                fill;
    logic signed [DELTA_W-1:0] below_peak;
    logic [TEMP_W-1:0]         peak_temp;
    logic [2:0]                peaked_cyl;
    logic                      peaked_valid;
    logic [2:0]                hottest_cyl;
    logic                      is_armed;
    logic                      phase_changed;
    logic [2:0]                phase_now;
  } report_t;

  typedef enum logic {ROW_FRAME, ROW_REGS} row_kind_t;
  typedef enum logic [1:0] {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  // directed table row: a frame (optionally with a hand-written result) or a
  // full register setting
  typedef struct {
    row_kind_t         kind;
    frame_t            frm;
    bit                typed;
    report_t           want;
    temp_t             arm;
    temp_t             drop;
    logic [CYL_W-1:0]  cyl;
    logic [HOLD_W-1:0] hold;
  } row_t;

  typedef struct {
    int      seq;
    report_t rep;
  } typed_report_t;

  // ---------------------------------------------------------------- DUT I/O
  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = CFG_ARM_RISE;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata = '0;   // now_ms, then temp_cyl0..5
  logic [IN_USER_W-1:0]   s_axis_tuser = '0;   // command, zero filled
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;        // report_t layout

  egt_peak_lean_finder_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  // ------------------------------------------------------- bench bookkeeping
  report_t       expected_reports[$];   // predicted results, oldest first
  typed_report_t table_reports[$];      // hand-written results from the table
  row_t          stim_table[$];
  int            frames_accepted   = 0; // owned by the sender
  int            reports_received  = 0; // owned by the result checker
  int            error_count       = 0;
  int            burst_left        = 0;
  int            hold_off_asked    = 0;
  int            hold_off_served   = 0;

  // predictor copy of the register file
  temp_t             set_arm_rise  = ARM_RISE_RST;
  temp_t             set_peak_drop = PEAK_DROP_RST;
  logic [CYL_W-1:0]  set_cyl_use   = CYL_USE_RST;
  logic [HOLD_W-1:0] set_hold_ms   = HOLD_MS_RST;

  // predictor copy of the lean-find state
  phase_t                    fp_phase    = PH_IDLE;
  logic [TIME_W-1:0]         fp_start_ms = '0;
  temp_t                     fp_base[LANES];
  temp_t                     fp_peak[LANES];
  logic                      fp_armed    = 1'b0;
  logic                      fp_peaked   = 1'b0;
  logic [CYL_W-1:0]          fp_peak_idx = '0;
  logic signed [DELTA_W-1:0] fp_delta    = '0;

  initial begin
    foreach (fp_base[i]) begin
      fp_base[i] = '0;
      fp_peak[i] = '0;
    end
  end

  // ------------------------------------------------------------- predictor
  function automatic void clear_lean_run();
    fp_armed    = 1'b0;
    fp_peaked   = 1'b0;
    fp_peak_idx = '0;
    fp_delta    = '0;
  endfunction

  // Advances the lean-find state by one frame and returns the result it causes.
  function automatic report_t step_peak_finder(frame_t f);
    report_t           r;
    int                n;
    int                hot;
    phase_t            prev;
    logic              snap;
    logic              found;
    logic [TIME_W-1:0] elapsed;
    r     = '0;
    snap  = 1'b0;
    found = 1'b0;
    prev  = fp_phase;
    // cylinder count: zero counts as one, above the lane count saturates
    if (set_cyl_use == 0) n = 1;
    else if (int'(set_cyl_use) > LANES) n = LANES;
    else n = int'(set_cyl_use);
    hot = 0;
    for (int i = 1; i < n; i++)
      if (f.temp[i] > f.temp[hot]) hot = i;

    if (f.cmd == CMD_START && fp_phase == PH_IDLE) begin
      fp_phase = PH_PRE;
      clear_lean_run();
    end else if (f.cmd == CMD_EXIT) begin
      if (fp_phase != PH_IDLE) begin
        fp_phase = PH_IDLE;
        clear_lean_run();
      end
    end else if (fp_phase != PH_IDLE) begin
      elapsed = f.now - fp_start_ms;  // wraps modulo 2^32
      if (fp_phase == PH_PRE && elapsed >= TIME_W'(set_hold_ms)) begin
        fp_phase = PH_LEAN;
        snap     = 1'b1;
      end
      if (fp_phase == PH_FOUND && elapsed >= TIME_W'(set_hold_ms))
        fp_phase = PH_FINAL;
      if (fp_phase == PH_FINAL && fp_peaked)
        fp_delta = $signed({1'b0, f.temp[fp_peak_idx]}) - $signed({1'b0, fp_peak[fp_peak_idx]});
      if (fp_phase == PH_LEAN) begin
        if (snap) begin
          // entry frame only loads baselines and peaks; tracking begins next frame
          for (int i = 0; i < n; i++) begin
            fp_base[i] = f.temp[i];
            fp_peak[i] = f.temp[i];
          end
          clear_lean_run();
        end else begin
          for (int i = 0; i < n; i++) begin
            if (f.temp[i] > fp_peak[i]) fp_peak[i] = f.temp[i];
            if (int'(f.temp[i]) - int'(fp_base[i]) >= int'(set_arm_rise)) fp_armed = 1'b1;
          end
          // lowest-numbered cylinder that dropped far enough wins
          if (fp_armed) begin
            for (int i = 0; i < n; i++) begin
              if (!found && int'(fp_peak[i]) - int'(f.temp[i]) >= int'(set_peak_drop)) begin
                found       = 1'b1;
                fp_peak_idx = CYL_W'(i);
                fp_peaked   = 1'b1;
                fp_phase    = PH_FOUND;
              end
            end
          end
        end
      end
    end
    if (fp_phase != prev) fp_start_ms = f.now;

    r.phase_now     = fp_phase;
    r.phase_changed = (fp_phase != prev);
    r.is_armed      = fp_armed;
    r.hottest_cyl   = CYL_W'(hot);
    r.peaked_valid  = fp_peaked;
    r.peaked_cyl    = fp_peaked ? fp_peak_idx : '0;
    r.peak_temp     = fp_peaked ? fp_peak[fp_peak_idx] : '0;
    r.below_peak    = (fp_phase == PH_FINAL) ? fp_delta : '0;
    return r;
  endfunction

  // ---------------------------------------------------------------- checking
  function automatic void flag_mismatch(string src, string field,
                                        logic signed [31:0] want, logic signed [31:0] got);
    $error("%s: %s expected %0d, got %0d", src, field, want, got);
    error_count++;
  endfunction

  function automatic void check_report(report_t want, report_t got, string src);
    if (got.phase_now !== want.phase_now)
      flag_mismatch(src, "phase_now", want.phase_now, got.phase_now);
    if (got.phase_changed !== want.phase_changed)
      flag_mismatch(src, "phase_changed", want.phase_changed, got.phase_changed);
    if (got.is_armed !== want.is_armed)
      flag_mismatch(src, "is_armed", want.is_armed, got.is_armed);
    if (got.hottest_cyl !== want.hottest_cyl)
      flag_mismatch(src, "hottest_cyl", want.hottest_cyl, got.hottest_cyl);
    if (got.peaked_valid !== want.peaked_valid)
      flag_mismatch(src, "peaked_valid", want.peaked_valid, got.peaked_valid);
    if (got.peaked_cyl !== want.peaked_cyl)
      flag_mismatch(src, "peaked_cyl", want.peaked_cyl, got.peaked_cyl);
    if (got.peak_temp !== want.peak_temp)
      flag_mismatch(src, "peak_temp", want.peak_temp, got.peak_temp);
    if (got.below_peak !== want.below_peak)
      flag_mismatch(src, "below_peak", want.below_peak, got.below_peak);
    if (got.fill !== want.fill)
      flag_mismatch(src, "zero fill", want.fill, got.fill);
  endfunction

  // Every accepted frame request is run through the predictor at the same edge.
  always @(posedge clk) begin
    frame_t f;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      f.cmd  = s_axis_tuser[CMD_W-1:0];
      f.now  = s_axis_tdata[TIME_W-1:0];
      f.temp = s_axis_tdata[IN_DATA_W-1:TIME_W];
      expected_reports.push_back(step_peak_finder(f));
    end
  end

  // Result requests: compare with the oldest prediction, and with the table
  // entry where the directed part wrote one by hand.
  always @(posedge clk) begin
    report_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = report_t'(m_axis_tdata);
      if (table_reports.size() != 0 && table_reports[0].seq == reports_received) begin
        check_report(table_reports[0].rep, got, "table");
        void'(table_reports.pop_front());
      end
      if (expected_reports.size() == 0) begin
        $error("result request %0d arrived with no prediction pending", reports_received);
        error_count++;
      end else begin
        check_report(expected_reports.pop_front(), got, "predictor");
      end
      reports_received++;
    end
  end

  // ---------------------------------------------------------------- receiver
  // Readiness follows a random mode that is redrawn after a random window; a hold-off
  // request from the sender side stalls it for a long stretch.
  initial begin
    rx_mode_t mode;
    int       window;
    mode   = RX_OPEN;
    window = 0;
    forever begin
      @(posedge clk);
      if (hold_off_asked != hold_off_served) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
        hold_off_served++;
      end else begin
        if (window == 0) begin
          mode   = rx_mode_t'($urandom_range(0, 3));
          window = $urandom_range(16, 96);
        end
        window--;
        case (mode)
          RX_OPEN:   m_axis_tready <= 1'b1;
          RX_MOSTLY: m_axis_tready <= ($urandom_range(0, 3) != 0);
          RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default:   m_axis_tready <= (window % 3 != 0);
        endcase
      end
    end
  end

  // ------------------------------------------------------------------ sender
  // Offers one frame and waits for the edge where it is accepted. Requests go
  // out in bursts; after a burst valid may drop for a random gap before return.
  task automatic send_frame(frame_t f);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {f.temp, f.now};
    s_axis_tuser  <= {{(IN_USER_W-CMD_W){1'b0}}, f.cmd};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    frames_accepted++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stops offering and waits until every accepted frame has its result back.
  task automatic wait_for_quiet();
    s_axis_tvalid <= 1'b0;
    while (reports_received != frames_accepted) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // Writes all four registers back to back; only called with the core quiet.
  task automatic write_regs(temp_t arm, temp_t drop, logic [CYL_W-1:0] cyl,
                            logic [HOLD_W-1:0] hold);
    cfg_reg_t              order[4] = '{CFG_ARM_RISE, CFG_PEAK_DROP, CFG_CYL_USE, CFG_HOLD_MS};
    logic [CFG_DATA_W-1:0] vals[4];
    vals = '{CFG_DATA_W'(arm), CFG_DATA_W'(drop), CFG_DATA_W'(cyl), hold};
    for (int k = 0; k < 4; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= order[k];
      cfg_data  <= vals[k];
      @(posedge clk);
    end
    cfg_we        <= 1'b0;
    set_arm_rise  = arm;
    set_peak_drop = drop;
    set_cyl_use   = cyl;
    set_hold_ms   = hold;
  endtask

  function automatic frame_t random_frame();
    frame_t f;
    f.cmd = CMD_W'($urandom_range(0, 3));
    f.now = $urandom();
    foreach (f.temp[i]) f.temp[i] = TEMP_W'($urandom_range(0, 4095));
    return f;
  endfunction

  // One lean-find run: start, flat pre-lean temperatures, then a per-cylinder
  // rise and fall once the hold time has passed, sprinkled with noise frames.
  task automatic run_lean_session();
    frame_t            f;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] start;
    int                step_max, frames, ramp, lean_idx, p, v;
    int                base[LANES];
    int                rise[LANES];
    int                fall[LANES];
    step_max = int'(set_hold_ms) / 3 + 3;
    if ($urandom_range(0, 7) == 0)
      now = 32'hFFFF_FFFF - $urandom_range(0, 4 * int'(set_hold_ms) + 64);  // wrap
    else
      now = $urandom();
    start    = now;
    frames   = $urandom_range(16, 48);
    ramp     = $urandom_range(2, 12);
    lean_idx = -1;
    for (int i = 0; i < LANES; i++) begin
      base[i] = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 4095) : $urandom_range(300, 1400);
      rise[i] = $urandom_range(0, 12);
      fall[i] = $urandom_range(0, 15);
    end
    for (int k = 0; k <= frames; k++) begin
      if (k > 0) begin
        now = now + TIME_W'($urandom_range(0, step_max));
        if (now - start >= TIME_W'(set_hold_ms)) lean_idx++;
      end
      p = (lean_idx < 0) ? 0 : lean_idx;
      for (int i = 0; i < LANES; i++) begin
        v = base[i] + rise[i] * ((p < ramp) ? p : ramp)
            - fall[i] * ((p > ramp) ? p - ramp : 0) + int'($urandom_range(0, 1));
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        f.temp[i] = TEMP_W'(v);
      end
      f.now = now;
      if (k == 0) f.cmd = CMD_START;
      else begin
        case ($urandom_range(0, 31))
          0:       f.cmd = CMD_SPARE;
          1:       f.cmd = CMD_START;  // already active: plain update
          default: f.cmd = CMD_FRAME;
        endcase
        if ($urandom_range(0, 15) == 0) f = random_frame();
      end
      send_frame(f);
    end
    if ($urandom_range(0, 4) != 0) begin
      f     = random_frame();
      f.cmd = CMD_EXIT;
      send_frame(f);
    end
  endtask

  // ---------------------------------------------------------- table helpers
  function automatic logic [LANES-1:0][TEMP_W-1:0] tset(int t0, int t1, int t2,
                                                        int t3, int t4, int t5);
    return {TEMP_W'(t5), TEMP_W'(t4), TEMP_W'(t3), TEMP_W'(t2), TEMP_W'(t1), TEMP_W'(t0)};
  endfunction

  function automatic report_t rpt(phase_t ph, bit chg, bit arm, int hot, bit pv,
                                  int pc, int pk, int below);
    report_t r;
    r               = '0;
    r.phase_now     = ph;
    r.phase_changed = chg;
    r.is_armed      = arm;
    r.hottest_cyl   = CYL_W'(hot);
    r.peaked_valid  = pv;
    r.peaked_cyl    = CYL_W'(pc);
    r.peak_temp     = TEMP_W'(pk);
    r.below_peak    = DELTA_W'(below);
    return r;
  endfunction

  function automatic row_t frame_row(logic [CMD_W-1:0] cmd, logic [TIME_W-1:0] now,
                                     logic [LANES-1:0][TEMP_W-1:0] temps);
    row_t r;
    r.kind     = ROW_FRAME;
    r.frm.cmd  = cmd;
    r.frm.now  = now;
    r.frm.temp = temps;
    r.typed    = 1'b0;
    r.want     = '0;
    r.arm      = '0;
    r.drop     = '0;
    r.cyl      = '0;
    r.hold     = '0;
    return r;
  endfunction

  function automatic row_t typed_row(logic [CMD_W-1:0] cmd, logic [TIME_W-1:0] now,
                                     logic [LANES-1:0][TEMP_W-1:0] temps, report_t want);
    row_t r;
    r       = frame_row(cmd, now, temps);
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  function automatic row_t regs_row(int arm, int drop, int cyl, int hold);
    row_t r;
    r.kind  = ROW_REGS;
    r.frm   = '0;
    r.typed = 1'b0;
    r.want  = '0;
    r.arm   = TEMP_W'(arm);
    r.drop  = TEMP_W'(drop);
    r.cyl   = CYL_W'(cyl);
    r.hold  = HOLD_W'(hold);
    return r;
  endfunction

  // ------------------------------------------------------------ main flow
  initial begin
    typed_report_t tr;
    int            session_no;

    // idle phase: frames, exit and the spare code change nothing
    stim_table.push_back(typed_row(CMD_FRAME, 32'd0, tset(0, 0, 0, 0, 0, 0),
                                   rpt(PH_IDLE, 0, 0, 0, 0, 0, 0, 0)));
    stim_table.push_back(typed_row(CMD_FRAME, 32'hFFFF_FFFF,
                                   tset(4095, 4095, 4095, 4095, 4095, 4095),
                                   rpt(PH_IDLE, 0, 0, 0, 0, 0, 0, 0)));
    stim_table.push_back(typed_row(CMD_FRAME, 32'h5555_AAAA, tset(0, 1, 2, 3, 4, 4095),
                                   rpt(PH_IDLE, 0, 0, 5, 0, 0, 0, 0)));
    stim_table.push_back(typed_row(CMD_EXIT, 32'd7, tset(9, 0, 0, 0, 9, 0),
                                   rpt(PH_IDLE, 0, 0, 0, 0, 0, 0, 0)));
    stim_table.push_back(typed_row(CMD_SPARE, 32'd8, tset(0, 0, 3000, 0, 0, 0),
                                   rpt(PH_IDLE, 0, 0, 2, 0, 0, 0, 0)));
    // default settings: full walk idle -> pre-lean -> leaning -> found -> final
    stim_table.push_back(typed_row(CMD_START, 32'd1000, tset(100, 100, 100, 100, 100, 100),
                                   rpt(PH_PRE, 1, 0, 0, 0, 0, 0, 0)));
    stim_table.push_back(frame_row(CMD_START, 32'd1500, tset(100, 100, 100, 100, 100, 100)));
    stim_table.push_back(typed_row(CMD_FRAME, 32'd1900, tset(100, 100, 100, 100, 100, 100),
                                   rpt(PH_LEAN, 1, 0, 0, 0, 0, 0, 0)));
    stim_table.push_back(frame_row(CMD_FRAME, 32'd1910, tset(100, 100, 130, 100, 100, 100)));
    stim_table.push_back(frame_row(CMD_FRAME, 32'd1920, tset(100, 100, 115, 100, 100, 100)));
    stim_table.push_back(typed_row(CMD_FRAME, 32'd2820, tset(100, 100, 100, 100, 100, 100),
                                   rpt(PH_FINAL, 1, 1, 0, 1, 2, 130, -30)));
    stim_table.push_back(frame_row(CMD_FRAME, 32'd2830, tset(0, 0, 4095, 0, 0, 0)));
    stim_table.push_back(typed_row(CMD_EXIT, 32'd2840, tset(0, 0, 0, 0, 0, 0),
                                   rpt(PH_IDLE, 1, 0, 0, 0, 0, 0, 0)));
    // zero thresholds, zero hold, cylinder count zero (one lane), time wrap
    stim_table.push_back(regs_row(0, 0, 0, 0));
    stim_table.push_back(frame_row(CMD_START, 32'hFFFF_FFF0,
                                   tset(50, 4095, 4095, 4095, 4095, 4095)));
    stim_table.push_back(frame_row(CMD_FRAME, 32'd5, tset(50, 4095, 0, 0, 0, 0)));
    stim_table.push_back(frame_row(CMD_FRAME, 32'd6, tset(50, 0, 4095, 0, 0, 0)));
    stim_table.push_back(frame_row(CMD_FRAME, 32'd7, tset(50, 0, 0, 0, 0, 0)));
    stim_table.push_back(frame_row(CMD_EXIT, 32'd8, tset(0, 0, 0, 0, 0, 0)));
    // top thresholds, longest hold, count seven saturating to six lanes
    stim_table.push_back(regs_row(4095, 4095, 7, 65535));
    stim_table.push_back(typed_row(CMD_START, 32'd0, tset(0, 0, 0, 0, 0, 0),
                                   rpt(PH_PRE, 1, 0, 0, 0, 0, 0, 0)));
    stim_table.push_back(frame_row(CMD_FRAME, 32'd65534, tset(0, 0, 0, 0, 0, 0)));
    stim_table.push_back(frame_row(CMD_FRAME, 32'd65535, tset(0, 0, 0, 0, 0, 0)));
    stim_table.push_back(frame_row(CMD_FRAME, 32'd65536, tset(0, 0, 0, 0, 0, 4095)));
    stim_table.push_back(frame_row(CMD_FRAME, 32'd65537, tset(0, 0, 0, 0, 0, 0)));
    stim_table.push_back(typed_row(CMD_FRAME, 32'd131072, tset(0, 0, 0, 0, 0, 0),
                                   rpt(PH_FINAL, 1, 1, 0, 1, 5, 4095, -4095)));
    stim_table.push_back(typed_row(CMD_EXIT, 32'd131073, tset(0, 0, 0, 0, 0, 0),
                                   rpt(PH_IDLE, 1, 0, 0, 0, 0, 0, 0)));

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_table[i]) begin
      if (stim_table[i].kind == ROW_REGS) begin
        wait_for_quiet();
        write_regs(stim_table[i].arm, stim_table[i].drop, stim_table[i].cyl, stim_table[i].hold);
      end else begin
        if (stim_table[i].typed) begin
          tr.seq = frames_accepted;
          tr.rep = stim_table[i].want;
          table_reports.push_back(tr);
        end
        send_frame(stim_table[i].frm);
      end
    end

    // randomized sessions; new settings only once the pipeline has drained,
    // which also gives the sender its full pause
    session_no = 0;
    while (frames_accepted < ITEM_TARGET) begin
      if (session_no == 0 || $urandom_range(0, 2) == 0) begin
        wait_for_quiet();
        write_regs(TEMP_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095)
                                                        : $urandom_range(0, 50)),
                   TEMP_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095)
                                                        : $urandom_range(0, 40)),
                   CYL_W'($urandom_range(0, 7)),
                   HOLD_W'(($urandom_range(0, 11) == 0) ? 32'hFFFF :
                           ($urandom_range(0, 10) == 0) ? $urandom_range(0, 65535) :
                                                          $urandom_range(0, 1200)));
      end
      // long receiver stall while frames keep coming: fills the result buffer
      if (session_no == 4 || session_no == 20) hold_off_asked++;
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) send_frame(random_frame());
      run_lean_session();
      session_no++;
    end

    wait_for_quiet();
    repeat (16) @(posedge clk);
    if (expected_reports.size() != 0) begin
      $error("%0d predicted results never arrived", expected_reports.size());
      error_count++;
    end
    if (error_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // hard stop in case the handshake hangs
  initial begin
    #(TIMEOUT_CYCLES * 2 * CLK_HALF);
    $display("Verification failed");
    $finish;
  end

endmodule
